/* src/smpcf_pkg.sv */
// Shared constants for the shadow map percentage-closer test unit.
package smpcf_pkg;

   localparam int MAP_WIDTH_MAX_DEF  = 1024;
   localparam int MAP_HEIGHT_MAX_DEF = 1024;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_PCF    = 2'd2;

   localparam logic [1:0] CSR_SHADOWS_ON = 2'd0;
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_BIAS_SCALE = 2'd3;

   localparam logic [17:0] FACING_FLOOR = 18'd13107;
   localparam logic [33:0] BIAS_SAT     = 34'h2_0000_0000;
   localparam logic [31:0] DEPTH_EMPTY  = 32'h8000_0000;

endpackage

/* src/smpcf_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module smpcf_div #(
   parameter int NW = 44,
   parameter int DW = 33,
   parameter int QW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] low_ff;
   logic [QW-1:0] quo_ff;
   logic [DW:0]   trial;
   logic          fits;

   // The caller guarantees that the quotient fits in QW bits.
   assign trial = {rem_ff, low_ff[QW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DW'(dividend >> QW);
         low_ff <= dividend[QW-1:0];
         den_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         low_ff <= {low_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/shadow_map_pcf_test_unit.sv */
// Top level of the shadow map percentage-closer test unit.
//
// After reset the unit sweeps the depth map once, one entry per cycle,
// and takes no request until the sweep is done; register writes are taken
// throughout. A write request is taken in the idle state. With shadows
// disabled a query goes straight to the finish state, and a rejected point
// passes through the check state first. A direct query reads one tap and a
// PCF query nine: one shared serial divider of QW = $clog2(max map size + 1)
// bits, 11 by default, forms the column and then the row at one bit per
// cycle, and the single memory port gives one tap read per cycle.
module shadow_map_pcf_test_unit #(
   parameter int MAP_WIDTH_MAX  = smpcf_pkg::MAP_WIDTH_MAX_DEF,
   parameter int MAP_HEIGHT_MAX = smpcf_pkg::MAP_HEIGHT_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_clip_x,
   input  logic signed [31:0] req_clip_y,
   input  logic signed [31:0] req_clip_z,
   input  logic signed [31:0] req_clip_w,
   input  logic signed [31:0] req_view_z,
   input  logic signed [15:0] req_facing,
   input  logic [19:0]        req_write_addr,
   input  logic signed [31:0] req_write_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_lit_count,
   output logic [3:0]         rsp_sample_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int ENTRIES  = MAP_WIDTH_MAX * MAP_HEIGHT_MAX;
   localparam int AW       = $clog2(ENTRIES);
   localparam int SIZE_MAX = (MAP_WIDTH_MAX > MAP_HEIGHT_MAX) ? MAP_WIDTH_MAX : MAP_HEIGHT_MAX;
   localparam int SW       = $clog2(SIZE_MAX + 1);
   localparam int NW       = 33 + SW;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_DIVX   = 3'd3;
   localparam logic [2:0] S_DIVY   = 3'd4;
   localparam logic [2:0] S_TAP    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic        shadows_on_ff;
   logic [10:0] map_width_ff, map_height_ff;
   logic [31:0] bias_scale_ff;

   logic               pcf_ff;
   logic signed [31:0] x_ff, y_ff, z_ff, w_ff, vz_ff;
   logic signed [15:0] fc_ff;

   logic [AW-1:0] clr_ff;
   logic [31:0]   mem [ENTRIES];
   logic [31:0]   rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_wdata;

   logic [SW-1:0] size_w, size_h, size_sel, q_clamp;
   logic [SW-1:0] cx_ff, cy_ff, ix, iy;
   logic [1:0]    tx_ff, ty_ff;
   logic          issue_ff, pend_ff, pend_k2_ff;
   logic [3:0]    lit_ff, samp_ff;
   logic          rsp_valid_ff;
   logic [3:0]    rsp_lit_ff, rsp_samp_ff;

   logic               accept, wr_ok, reject, tap_last, tap_k2, tap_pass;
   logic signed [33:0] w_s, nw_s, x_s, y_s, z_s, c_s, num_s;
   logic [32:0]        num_u, den_u;
   logic [NW-1:0]      div_dividend;
   logic               div_start, div_done;
   logic [SW-1:0]      div_q;
   logic [AW-1:0]      tap_addr;

   logic signed [18:0] m_s;
   logic [17:0]        m_u;
   logic [31:0]        v_u;
   logic [49:0]        p_ff, a_ff, mag;
   logic [63:0]        b_ff;
   logic [33:0]        mag_sat;
   logic signed [34:0] bias_ff;
   logic signed [37:0] t1_ff, t2_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shadows_on_ff <= 1'b1;
         map_width_ff  <= 11'd1024;
         map_height_ff <= 11'd1024;
         bias_scale_ff <= 32'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            smpcf_pkg::CSR_SHADOWS_ON: shadows_on_ff <= csr_data[0];
            smpcf_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_data[10:0];
            smpcf_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_data[10:0];
            smpcf_pkg::CSR_BIAS_SCALE: bias_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign size_w = (map_width_ff == 11'd0) ? SW'(1) :
                   ((32'(map_width_ff) > 32'(MAP_WIDTH_MAX)) ? SW'(MAP_WIDTH_MAX) :
                    SW'(map_width_ff));
   assign size_h = (map_height_ff == 11'd0) ? SW'(1) :
                   ((32'(map_height_ff) > 32'(MAP_HEIGHT_MAX)) ? SW'(MAP_HEIGHT_MAX) :
                    SW'(map_height_ff));

   // Query operands.
   always_ff @(posedge clock) begin
      if (accept) begin
         pcf_ff <= req_mode == smpcf_pkg::MODE_PCF;
         x_ff   <= req_clip_x;
         y_ff   <= req_clip_y;
         z_ff   <= req_clip_z;
         w_ff   <= req_clip_w;
         vz_ff  <= req_view_z;
         fc_ff  <= req_facing;
      end
   end

   assign w_s    = 34'(w_ff);
   assign nw_s   = -w_s;
   assign x_s    = 34'(x_ff);
   assign y_s    = 34'(y_ff);
   assign z_s    = 34'(z_ff);
   assign reject = (w_ff == 32'sd0) || (x_s < w_s) || (x_s > nw_s) || (y_s < w_s) ||
                   (y_s > nw_s) || (z_s < w_s) || (z_s > nw_s);

   assign c_s          = (state_ff == S_CHECK) ? x_s : y_s;
   assign size_sel     = (state_ff == S_CHECK) ? size_w : size_h;
   assign num_s        = -(c_s + w_s);
   assign num_u        = num_s[32:0];
   assign den_u        = {nw_s[31:0], 1'b0};
   assign div_dividend = {{SW{1'b0}}, num_u} * {{33{1'b0}}, size_sel};
   assign div_start    = ((state_ff == S_CHECK) && !reject) ||
                         ((state_ff == S_DIVX) && div_done);

   smpcf_div #(
      .NW(NW),
      .DW(33),
      .QW(SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_u),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_clamp = (state_ff == S_DIVX) ?
                    ((div_q > size_w - 1'b1) ? size_w - 1'b1 : div_q) :
                    ((div_q > size_h - 1'b1) ? size_h - 1'b1 : div_q);

   // Bias pipeline; it settles well before the divides finish.
   assign m_s     = 19'sd65536 - (19'(fc_ff) <<< 1);
   assign m_u     = (m_s < 19'sd13107) ? smpcf_pkg::FACING_FLOOR : m_s[17:0];
   assign v_u     = (vz_ff < 32'sd0) ? 32'(-(33'(vz_ff))) : 32'(vz_ff);
   assign mag     = a_ff + 50'(b_ff[63:32]);
   assign mag_sat = (mag > 50'(smpcf_pkg::BIAS_SAT)) ? smpcf_pkg::BIAS_SAT : mag[33:0];

   always_ff @(posedge clock) begin
      p_ff    <= 50'(m_u) * 50'(bias_scale_ff);
      a_ff    <= 50'(p_ff[49:32]) * 50'(v_u);
      b_ff    <= 64'(p_ff[31:0]) * 64'(v_u);
      bias_ff <= (vz_ff > 32'sd0) ? -$signed(35'(mag_sat)) : $signed(35'(mag_sat));
      t1_ff   <= 38'(vz_ff) + 38'(bias_ff);
      t2_ff   <= 38'(vz_ff) + (38'(bias_ff) <<< 1);
   end

   // Tap address with the window clamped to the map.
   always_comb begin
      case (tx_ff)
         2'd0:    ix = (cx_ff == '0) ? cx_ff : cx_ff - 1'b1;
         2'd2:    ix = (cx_ff == size_w - 1'b1) ? cx_ff : cx_ff + 1'b1;
         default: ix = cx_ff;
      endcase
      case (ty_ff)
         2'd0:    iy = (cy_ff == '0) ? cy_ff : cy_ff - 1'b1;
         2'd2:    iy = (cy_ff == size_h - 1'b1) ? cy_ff : cy_ff + 1'b1;
         default: iy = cy_ff;
      endcase
   end

   assign tap_addr = AW'({{SW{1'b0}}, iy} * {{SW{1'b0}}, size_w} + {{SW{1'b0}}, ix});
   assign tap_last = !pcf_ff || ((tx_ff == 2'd2) && (ty_ff == 2'd2));
   assign tap_k2   = !((tx_ff == 2'd1) && (ty_ff == 2'd1));
   assign tap_pass = (pend_k2_ff ? t2_ff : t1_ff) > 38'($signed(rd_ff));

   assign wr_ok     = 32'(req_write_addr) < 32'(ENTRIES);
   assign mem_we    = (state_ff == S_CLEAR) ||
                      (accept && (req_mode == smpcf_pkg::MODE_WRITE) && wr_ok);
   assign mem_addr  = (state_ff == S_CLEAR) ? clr_ff :
                      ((state_ff == S_IDLE) ? AW'(req_write_addr) : tap_addr);
   assign mem_wdata = (state_ff == S_CLEAR) ? smpcf_pkg::DEPTH_EMPTY : req_write_depth;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept && ((req_mode == smpcf_pkg::MODE_DIRECT) ||
                           (req_mode == smpcf_pkg::MODE_PCF))) begin
               state_in = shadows_on_ff ? S_CHECK : S_FINISH;
            end
         end
         S_CHECK: begin
            state_in = reject ? S_FINISH : S_DIVX;
         end
         S_DIVX: begin
            if (div_done) state_in = S_DIVY;
         end
         S_DIVY: begin
            if (div_done) state_in = S_TAP;
         end
         S_TAP: begin
            if (!issue_ff && !pend_ff) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if ((state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         pend_ff <= (state_ff == S_TAP) && issue_ff;
         if ((state_ff == S_DIVY) && div_done) begin
            issue_ff <= 1'b1;
         end else if ((state_ff == S_TAP) && issue_ff && tap_last) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lit_ff  <= 4'd1;
         samp_ff <= 4'd1;
      end
      if ((state_ff == S_CHECK) && reject) begin
         lit_ff <= 4'd0;
      end
      if ((state_ff == S_DIVX) && div_done) begin
         cx_ff <= q_clamp;
      end
      if ((state_ff == S_DIVY) && div_done) begin
         cy_ff   <= q_clamp;
         tx_ff   <= pcf_ff ? 2'd0 : 2'd1;
         ty_ff   <= pcf_ff ? 2'd0 : 2'd1;
         lit_ff  <= 4'd0;
         samp_ff <= pcf_ff ? 4'd9 : 4'd1;
      end
      if ((state_ff == S_TAP) && issue_ff) begin
         pend_k2_ff <= tap_k2;
         if (tx_ff == 2'd2) begin
            tx_ff <= 2'd0;
            ty_ff <= ty_ff + 1'b1;
         end else begin
            tx_ff <= tx_ff + 1'b1;
         end
      end
      if (pend_ff && tap_pass) begin
         lit_ff <= lit_ff + 1'b1;
      end
      if ((state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_lit_ff  <= lit_ff;
         rsp_samp_ff <= samp_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lit_count    = rsp_lit_ff;
   assign rsp_sample_count = rsp_samp_ff;

   a_lit_le_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lit_count <= rsp_sample_count)
      else $error("lit count exceeds sample count");

   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_sample_count == 4'd1) || (rsp_sample_count == 4'd9)))
      else $error("unexpected sample count");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == S_DIVX) || (state_ff == S_DIVY)))
      else $error("divider finished outside a divide state");

endmodule

/* bench/shadow_map_pcf_test_unit_tb.sv */
// Self-checking testbench for the shadow map percentage-closer test unit.
`timescale 1ns / 1ps

module shadow_map_pcf_test_unit_tb;

   localparam int WMAX = smpcf_pkg::MAP_WIDTH_MAX_DEF;
   localparam int HMAX = smpcf_pkg::MAP_HEIGHT_MAX_DEF;
   localparam int IDLE_LIMIT = 4200000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [3:0] lit;
      logic [3:0] taps;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = smpcf_pkg::MODE_WRITE;
   logic signed [31:0] req_clip_x = '0, req_clip_y = '0, req_clip_z = '0;
   logic signed [31:0] req_clip_w = '0, req_view_z = '0, req_write_depth = '0;
   logic signed [15:0] req_facing = '0;
   logic [19:0] req_write_addr = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_lit_count, rsp_sample_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = smpcf_pkg::CSR_SHADOWS_ON;
   logic [31:0] csr_data = '0;

   logic [31:0] depth_store [int];
   logic shadows_on_q = 1'b1;
   logic [10:0] width_q = 11'd1024, height_q = 11'd1024;
   logic [31:0] bias_scale_q = '0;
   shade_type shade_queue [$];
   int mismatches = 0, checked = 0, idle_cycles = 0, sent = 0;
   bit timed_out = 1'b0;
   bit hold_req = 1'b0;
   bit hold_used = 1'b0;
   int hold_count = 0;

   shadow_map_pcf_test_unit u_dut (.*);

   always #4 clock = ~clock;

   function automatic logic signed [31:0] depth_at(int a);
      if (depth_store.exists(a)) return depth_store[a];
      return smpcf_pkg::DEPTH_EMPTY;
   endfunction

   function automatic longint eff(logic [10:0] v, int mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : v;
   endfunction

   function automatic longint pixel_of(longint c, longint w, longint sz);
      longint p;
      p = (-(c + w)) * sz / (-2 * w);
      return (p > sz - 1) ? sz - 1 : p;
   endfunction

   function automatic longint slope_bias(longint vz, longint fc);
      longint m;
      logic [63:0] p, ph, pl, v, mag;
      m = 2 * (32768 - fc);
      if (m < longint'(smpcf_pkg::FACING_FLOOR)) m = longint'(smpcf_pkg::FACING_FLOOR);
      p = 64'(m) * 64'(bias_scale_q);
      ph = p >> 32;
      pl = p & 64'hFFFF_FFFF;
      v = (vz < 0) ? -vz : vz;
      mag = ph * v + ((pl * v) >> 32);
      if (mag > 64'(smpcf_pkg::BIAS_SAT)) mag = 64'(smpcf_pkg::BIAS_SAT);
      return (vz > 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic shade_type shade_point(logic [1:0] md, longint x, longint y,
                                             longint z, longint w, longint vz,
                                             longint fc);
      shade_type r;
      longint W, H, cx, cy, b, ix, iy, k;
      r.lit = 0;
      r.taps = 1;
      if (!shadows_on_q) begin
         r.lit = 1;
         return r;
      end
      if (w == 0 || x < w || x > -w || y < w || y > -w || z < w || z > -w)
         return r;
      W = eff(width_q, WMAX);
      H = eff(height_q, HMAX);
      cx = pixel_of(x, w, W);
      cy = pixel_of(y, w, H);
      b = slope_bias(vz, fc);
      if (md == smpcf_pkg::MODE_DIRECT) begin
         r.lit = (vz + b > longint'(depth_at(int'(cy * W + cx))));
         return r;
      end
      r.taps = 0;
      for (int dy = -1; dy <= 1; dy++)
         for (int dx = -1; dx <= 1; dx++) begin
            ix = cx + dx; iy = cy + dy;
            if (ix < 0) ix = 0;
            if (ix > W - 1) ix = W - 1;
            if (iy < 0) iy = 0;
            if (iy > H - 1) iy = H - 1;
            k = ((dx != 0 || dy != 0) ? 2 : 1);
            if (vz + k * b > longint'(depth_at(int'(iy * W + ix)))) r.lit++;
            r.taps++;
         end
      return r;
   endfunction

   task automatic send_request(logic [1:0] md, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] w, logic [31:0] vz,
                               logic [15:0] fc, logic [19:0] wa, logic [31:0] wd);
      req_valid <= 1'b1;
      req_mode <= md;
      req_clip_x <= x; req_clip_y <= y; req_clip_z <= z; req_clip_w <= w;
      req_view_z <= vz; req_facing <= fc;
      req_write_addr <= wa; req_write_depth <= wd;
      do @(posedge clock); while (req_stall);
      sent++;
      if (md == smpcf_pkg::MODE_WRITE) depth_store[int'(wa)] = wd;
      else if (md != MODE_UNUSED)
         shade_queue.push_back(shade_point(md, $signed(x), $signed(y), $signed(z),
                                           $signed(w), $signed(vz), $signed(fc)));
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shade_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] d);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         smpcf_pkg::CSR_SHADOWS_ON: shadows_on_q = d[0];
         smpcf_pkg::CSR_MAP_WIDTH: width_q = d[10:0];
         smpcf_pkg::CSR_MAP_HEIGHT: height_q = d[10:0];
         default: bias_scale_q = d;
      endcase
   endtask

   task automatic configure(logic s, logic [10:0] w, logic [10:0] h, logic [31:0] b);
      drain();
      write_csr(smpcf_pkg::CSR_SHADOWS_ON, 32'(s));
      write_csr(smpcf_pkg::CSR_MAP_WIDTH, 32'(w));
      write_csr(smpcf_pkg::CSR_MAP_HEIGHT, 32'(h));
      write_csr(smpcf_pkg::CSR_BIAS_SCALE, b);
   endtask

   task automatic send_query(logic [1:0] md);
      logic [31:0] cw, x, y, z;
      cw = -$urandom_range(1, 32'h7FFF_FFFF);
      if ($urandom_range(0, 3) == 0) cw = $urandom;
      x = 32'($signed(cw) + longint'($urandom) % (-2 * longint'($signed(cw)) + 1));
      y = 32'($signed(cw) + longint'($urandom) % (-2 * longint'($signed(cw)) + 1));
      z = 32'($signed(cw) + longint'($urandom) % (-2 * longint'($signed(cw)) + 1));
      if ($urandom_range(0, 9) == 0) x = $urandom;
      send_request(md, x, y, z, cw, $urandom, 16'($urandom), '0, '0);
   endtask

   task automatic write_near(int ww);
      int a;
      a = $urandom_range(0, 15) * ww + $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 20'hFFFFF);
      send_request(smpcf_pkg::MODE_WRITE, '0, '0, '0, '0, '0, '0, 20'(a), $urandom);
   endtask

   task automatic test_directed();
      configure(1'b1, 11'd4, 11'd4, 32'h0001_0000);
      for (int i = 0; i < 16; i++)
         send_request(smpcf_pkg::MODE_WRITE, '0, '0, '0, '0, '0, '0, 20'(i),
                      (i % 2) ? 32'h7FFF_FFFF : 32'hFFF0_0000);
      send_request(smpcf_pkg::MODE_WRITE, '0, '0, '0, '0, '0, '0, 20'hFFFFF, 32'h1234);
      send_request(smpcf_pkg::MODE_DIRECT, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000,
                   16'h7FFF, '0, '0);
      send_request(smpcf_pkg::MODE_PCF, 32'hFFFF_0000, 32'h0001_0000, 0, 32'hFFFF_0000,
                   32'h0002_0000, 16'h8000, '0, '0);
      send_request(smpcf_pkg::MODE_PCF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, '0, '0);
      send_request(smpcf_pkg::MODE_DIRECT, 0, 0, 0, 0, 0, 0, '0, '0);
      send_request(smpcf_pkg::MODE_PCF, 0, 0, 0, 32'h0001_0000, 0, 0, '0, '0);
      send_request(MODE_UNUSED, 0, 0, 0, 32'hFFFF_0000, 0, 0, '0, '0);
      send_request(smpcf_pkg::MODE_DIRECT, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_0000, 0, 0,
                   '0, '0);
   endtask

   task automatic test_random(int n, logic [10:0] w);
      int ww;
      ww = int'(eff(w, WMAX));
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1, 2: write_near(ww);
            3: send_request(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom,
                            $urandom, 16'($urandom), 20'($urandom), $urandom);
            4, 5, 6: send_query(smpcf_pkg::MODE_DIRECT);
            default: send_query(smpcf_pkg::MODE_PCF);
         endcase
      end
   endtask

   task automatic test_settings();
      logic [10:0] sz [6] = '{11'd0, 11'd1, 11'd3, 11'd16, 11'd1024, 11'd2047};
      for (int p = 0; p < 6; p++) begin
         configure(p != 2, sz[p], sz[5 - p],
                   (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom_range(0, 32'h4_0000));
         test_random(200, sz[p]);
      end
   endtask

   task automatic test_backpressure();
      configure(1'b1, 11'd16, 11'd16, 32'h0000_8000);
      hold_req = 1'b1;
      test_random(100, 11'd16);
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_count <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= (($urandom_range(0, 3) == 0) && (sent % 200 < 150));
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (rsp_valid && !rsp_stall && !reset) begin
         checked++;
         if (shade_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %0d/%0d",
                                           rsp_lit_count, rsp_sample_count);
         end else begin
            shade_type e;
            e = shade_queue.pop_front();
            if (e.lit !== rsp_lit_count || e.taps !== rsp_sample_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                           e.lit, e.taps, rsp_lit_count, rsp_sample_count);
            end
         end
      end
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("** shadow_map_pcf_test_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings();
      test_backpressure();
      drain();
      $display("Covered %0d requests and %0d results across six map settings,",
               sent, checked);
      $display("with shadows toggled, bias extremes and long output stalls.");
      if (mismatches == 0 && shade_queue.size() == 0)
         $display("** shadow_map_pcf_test_unit: PASSED **");
      else
         $display("** shadow_map_pcf_test_unit: FAILED **");
      $finish;
   end
endmodule
